### src/pbi_pkg.sv
package pbi_pkg;

  localparam int PIX_W             = 16;
  localparam int IDX_OUT_W         = 8;
  localparam int SIZE_OUT_W        = 9;
  localparam int IN_TDATA_W        = 16;
  localparam int OUT_TDATA_W       = 24;
  localparam int OUT_TUSER_W       = 2;
  localparam int DEF_PALETTE_DEPTH = 256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } pbi_state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic decide;
    logic emit;
  } pbi_cmd_t;

  typedef struct packed {
    logic done;
  } pbi_status_t;

endpackage

### src/palette_builder_indexer_core.sv
// Palette builder and indexer. Each pixel colour is looked up in a palette of up to
// PALETTE_DEPTH colours, first match from entry 0 upward; a miss appends the colour and
// flags it as new, and a miss on a full palette raises a sticky overflow until the pixel
// marked tlast, after which palette and overflow are cleared (by resetting the fill
// count, so no clearing pass is needed). One pixel is in flight at a time. The search
// reads the palette through its single read port, one entry per cycle, and stops at
// the first match on a hit or after all filled entries on a miss; an empty palette or
// a set overflow skips the search. The next pixel can be taken in the same cycle as the
// result appears, and a finished result waits in an output register while the next
// pixel is taken.
module palette_builder_indexer_core #(
  parameter int PALETTE_DEPTH = pbi_pkg::DEF_PALETTE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pbi_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] pixel_color
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pbi_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] color_index, [16:8] palette_size
  output logic [pbi_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] is_new_entry, [1] overflow
  output logic                            out_tlast
);
  import pbi_pkg::*;

  pbi_cmd_t    cmd;
  pbi_status_t status;

  pbi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pbi_dpath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  a_new_not_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("new entry reported together with overflow");

  a_ovf_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata[7:0] == '0))
    else $error("overflowed result with non-zero index");

  a_new_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[7:0] == 8'(out_tdata[16:8] - 9'd1)))
    else $error("palette size does not follow new entry index");

endmodule

### src/pbi_ctrl.sv
module pbi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  pbi_pkg::pbi_status_t status,
  output pbi_pkg::pbi_cmd_t    cmd
);
  import pbi_pkg::*;

  pbi_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.done) begin
          cmd.decide = 1'b1;
          state_nxt  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

### src/pbi_dpath.sv
module pbi_dpath #(
  parameter int PALETTE_DEPTH = pbi_pkg::DEF_PALETTE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pbi_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  input  pbi_pkg::pbi_cmd_t               cmd,
  output pbi_pkg::pbi_status_t            status,
  output logic [pbi_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [pbi_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import pbi_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int IW = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;
  localparam int SW = (CW > SIZE_OUT_W) ? CW : SIZE_OUT_W;
  localparam int PADW = OUT_TDATA_W - IDX_OUT_W - SIZE_OUT_W;

  logic [PIX_W-1:0] palette [PALETTE_DEPTH];

  logic [PIX_W-1:0]      color_r;
  logic                  last_r;
  logic [CW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]         cmp_addr_r;
  logic [PIX_W-1:0]      rdata_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [IDX_OUT_W-1:0]  res_index_r;
  logic                  res_fresh_r, res_ovf_r, res_last_r;
  logic [SIZE_OUT_W-1:0] res_size_r;

  logic [IDX_OUT_W-1:0]  out_index_r;
  logic                  out_fresh_r, out_ovf_r, out_last_r;
  logic [SIZE_OUT_W-1:0] out_size_r;

  logic                  issue, hit, miss, full, wr_en;
  logic [CW-1:0]         new_count;
  logic                  new_ovf;
  logic [AW-1:0]         new_index;
  logic [IW-1:0]         index_ext;
  logic [SW-1:0]         size_ext;

  assign issue = cmd.search && (rd_cnt_r < count_r);
  assign hit   = cmp_v_r && (rdata_r == color_r);
  assign miss  = !cmp_v_r && (rd_cnt_r >= count_r);
  assign full  = count_r >= CW'(PALETTE_DEPTH);
  assign status.done = ovf_r || hit || miss;

  assign wr_en     = cmd.decide && !ovf_r && !hit && !full;
  assign new_count = wr_en ? count_r + CW'(1) : count_r;
  assign new_ovf   = ovf_r || (!hit && full);
  assign new_index = (!ovf_r && hit) ? cmp_addr_r :
                     wr_en ? count_r[AW-1:0] : '0;
  assign index_ext = IW'(new_index);
  assign size_ext  = SW'(new_count);

  // palette memory: one read and one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= palette[rd_cnt_r[AW-1:0]];
    end
    if (wr_en) begin
      palette[count_r[AW-1:0]] <= color_r;
    end
  end

  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    cmp_v_nxt  = cmp_v_r;
    if (cmd.load) begin
      rd_cnt_nxt = '0;
      cmp_v_nxt  = 1'b0;
    end else if (cmd.search) begin
      rd_cnt_nxt = issue ? rd_cnt_r + CW'(1) : rd_cnt_r;
      cmp_v_nxt  = issue;
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.decide) begin
      count_nxt = last_r ? '0 : new_count;
      ovf_nxt   = last_r ? 1'b0 : new_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      cmp_v_r  <= 1'b0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      rd_cnt_r <= rd_cnt_nxt;
      cmp_v_r  <= cmp_v_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      color_r <= in_tdata[PIX_W-1:0];
      last_r  <= in_tlast;
    end
    if (issue) begin
      cmp_addr_r <= rd_cnt_r[AW-1:0];
    end
    if (cmd.decide) begin
      res_index_r <= index_ext[IDX_OUT_W-1:0];
      res_fresh_r <= wr_en;
      res_ovf_r   <= new_ovf;
      res_size_r  <= size_ext[SIZE_OUT_W-1:0];
      res_last_r  <= last_r;
    end
    if (cmd.emit) begin
      out_index_r <= res_index_r;
      out_fresh_r <= res_fresh_r;
      out_ovf_r   <= res_ovf_r;
      out_size_r  <= res_size_r;
      out_last_r  <= res_last_r;
    end
  end

  assign out_tdata = {{PADW{1'b0}}, out_size_r, out_index_r};
  assign out_tuser = {out_ovf_r, out_fresh_r};
  assign out_tlast = out_last_r;

endmodule

### verif/palette_builder_indexer_core_tb.sv
`timescale 1ns / 100ps

module palette_builder_indexer_core_tb;
  import pbi_pkg::*;

  localparam int DEPTH        = DEF_PALETTE_DEPTH;
  localparam int TOTAL_ITEMS  = 850;
  localparam int DRAIN_CYCLES = DEPTH + 40;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  color_index;
    logic                  is_new_entry;
    logic                  overflow;
    logic [SIZE_OUT_W-1:0] palette_size;
    logic                  image_done;
  } pixel_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  logic [PIX_W-1:0] palette_copy [DEPTH];
  int unsigned      palette_fill;
  logic             overflow_latched;
  pixel_result_t    pending_lookups [$];

  int  mismatch_count;
  int  result_num;
  int  items_sent;
  int  cycle_count;
  int  ready_hold;
  bit  idle_enable;

  palette_builder_indexer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int find_colour(input logic [PIX_W-1:0] colour);
    for (int i = 0; i < palette_fill; i++)
      if (palette_copy[i] == colour) return i;
    return -1;
  endfunction

  function automatic logic [PIX_W-1:0] fresh_colour();
    logic [PIX_W-1:0] c;
    do c = PIX_W'($urandom); while (find_colour(c) >= 0);
    return c;
  endfunction

  function automatic void predict_palette_lookup(input logic [PIX_W-1:0] colour, input logic last);
    pixel_result_t r;
    int            hit;
    r = '0;
    if (!overflow_latched) begin
      hit = find_colour(colour);
      if (hit >= 0) begin
        r.color_index = IDX_OUT_W'(hit);
      end else if (palette_fill >= DEPTH) begin
        overflow_latched = 1'b1;
      end else begin
        palette_copy[palette_fill] = colour;
        r.color_index  = IDX_OUT_W'(palette_fill);
        r.is_new_entry = 1'b1;
        palette_fill++;
      end
    end
    r.overflow     = overflow_latched;
    r.palette_size = SIZE_OUT_W'(palette_fill);
    r.image_done   = last;
    pending_lookups.push_back(r);
    if (last) begin
      palette_fill     = 0;
      overflow_latched = 1'b0;
    end
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] colour, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      in_tlast  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= colour;
    in_tlast  <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    predict_palette_lookup(colour, last);
    items_sent++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h", result_num, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected transfer, tdata", int'(out_tdata), 0);
      end else begin
        want = pending_lookups.pop_front();
        if (out_tdata[IDX_OUT_W-1:0] !== want.color_index)
          report_mismatch("color_index", int'(out_tdata[IDX_OUT_W-1:0]),
                          int'(want.color_index));
        if (out_tdata[IDX_OUT_W +: SIZE_OUT_W] !== want.palette_size)
          report_mismatch("palette_size", int'(out_tdata[IDX_OUT_W +: SIZE_OUT_W]),
                          int'(want.palette_size));
        if (out_tdata[OUT_TDATA_W-1:IDX_OUT_W+SIZE_OUT_W] !== '0)
          report_mismatch("tdata padding",
                          int'(out_tdata[OUT_TDATA_W-1:IDX_OUT_W+SIZE_OUT_W]), 0);
        if (out_tuser[0] !== want.is_new_entry)
          report_mismatch("is_new_entry", int'(out_tuser[0]), int'(want.is_new_entry));
        if (out_tuser[1] !== want.overflow)
          report_mismatch("overflow", int'(out_tuser[1]), int'(want.overflow));
        if (out_tlast !== want.image_done)
          report_mismatch("image_done", int'(out_tlast), int'(want.image_done));
      end
      result_num++;
    end
  end

  // consumer back-pressure
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!idle_enable || $urandom_range(0, 2) != 0) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    end
  end

  task automatic test_directed_cases();
    idle_enable = 1'b1;
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h7FFE, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    // single-pixel image, miss on the last pixel
    send_pixel(16'hFFFF, 1'b1);
    // palette must start empty again
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'h1234, 1'b1);
  endtask

  // fill to exactly DEPTH entries, hit across it, overflow on the last pixel
  task automatic test_palette_fill();
    idle_enable = 1'b0;
    for (int i = 0; i < DEPTH; i++) send_pixel(fresh_colour(), 1'b0);
    idle_enable = 1'b1;
    send_pixel(palette_copy[0], 1'b0);
    send_pixel(palette_copy[DEPTH-1], 1'b0);
    repeat (18) send_pixel(palette_copy[$urandom_range(0, DEPTH-1)], 1'b0);
    send_pixel(fresh_colour(), 1'b1);
  endtask

  // overflow mid-image, then stored and new colours until the image ends
  task automatic test_overflow();
    idle_enable = 1'b1;
    for (int i = 0; i < DEPTH; i++) send_pixel(fresh_colour(), 1'b0);
    send_pixel(fresh_colour(), 1'b0);
    send_pixel(palette_copy[0], 1'b0);
    send_pixel(palette_copy[DEPTH-1], 1'b0);
    repeat (4) send_pixel(fresh_colour(), 1'b0);
    repeat (4) send_pixel(palette_copy[$urandom_range(0, DEPTH-1)], 1'b0);
    send_pixel(palette_copy[17], 1'b1);
  endtask

  task automatic test_random_images();
    logic [PIX_W-1:0] pool [16];
    int               pool_size;
    int               img_len;
    int               r;
    logic [PIX_W-1:0] colour;
    while (items_sent < TOTAL_ITEMS) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      img_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
      pool_size = $urandom_range(1, 16);
      for (int i = 0; i < pool_size; i++) begin
        r = $urandom_range(0, 9);
        pool[i] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : PIX_W'($urandom);
      end
      for (int n = 0; n < img_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70)
          colour = pool[$urandom_range(0, pool_size-1)];
        else if (r < 85 || palette_fill == 0)
          colour = PIX_W'($urandom);
        else
          colour = palette_copy[$urandom_range(0, palette_fill-1)];
        send_pixel(colour, n == img_len - 1);
      end
    end
  endtask

  initial begin
    mismatch_count   = 0;
    result_num       = 0;
    items_sent       = 0;
    palette_fill     = 0;
    overflow_latched = 1'b0;
    idle_enable      = 1'b0;
    cycle_count      <= 0;
    ready_hold       <= 0;
    rst_n            <= 1'b0;
    in_tvalid        <= 1'b0;
    in_tdata         <= '0;
    in_tlast         <= 1'b0;
    out_tready       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_palette_fill();
    test_overflow();
    test_random_images();

    in_tvalid <= 1'b0;
    idle_enable = 1'b1;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
